@@ src/bmth_pkg.sv @@
// shared types and codes for the bus member transmit handshake block
// no dependencies
`default_nettype none
package bmth_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;

  typedef enum logic [3:0] {
    REQ_START   = 4'd0,
    REQ_TURN    = 4'd1,
    REQ_FAIL    = 4'd2,
    REQ_SUCCESS = 4'd3,
    REQ_XMIT    = 4'd4,
    REQ_JOIN    = 4'd5,
    REQ_QUIT    = 4'd6,
    REQ_APP     = 4'd7,
    REQ_TIMEOUT = 4'd8
  } req_t;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_TX_OK        = 4'd1,
    EV_TX_FAILED    = 4'd2,
    EV_PEER_DATA    = 4'd3,
    EV_TOPIC_DATA   = 4'd4,
    EV_JOINED       = 4'd5,
    EV_QUIT         = 4'd6,
    EV_CONNECTED    = 4'd7,
    EV_DISCONNECTED = 4'd8,
    EV_REREGISTER   = 4'd9
  } app_event_t;

  typedef enum logic [1:0] {
    SEND_NOTHING = 2'd0,
    SEND_PACKET  = 2'd1,
    SEND_SUCCESS = 2'd2
  } send_kind_t;

  typedef enum logic [2:0] {
    REG_OWN_ADDRESS  = 3'd0,
    REG_TOPIC_LOW    = 3'd1,
    REG_TOPIC_HIGH   = 3'd2,
    REG_IDLE_TMO     = 3'd3,
    REG_RESPONSE_TMO = 3'd4
  } reg_idx_t;

  localparam logic [15:0] IDLE_TMO_RESET     = 16'd1000;
  localparam logic [15:0] RESPONSE_TMO_RESET = 16'd10;
  localparam logic [2:0]  MAX_RETRY_REASON   = 3'd3;

  typedef struct packed {
    logic        device_ready;
    logic        class_match;
    logic [2:0]  fail_reason;
    logic [6:0]  source_address;
    logic [7:0]  peer_field;
  } in_beat_t;

  typedef struct packed {
    logic        has_pending;
    logic        is_active;
    logic [15:0] timeout_ms;
    logic        timer_stop;
    logic        timer_arm;
    logic [2:0]  fail_code;
    logic [7:0]  event_address;
    send_kind_t  send_kind;
  } out_beat_t;

endpackage
`default_nettype wire

@@ src/bus_member_transmit_handshake.sv @@
// path from input beat to result beat: input register, then result register
// throughput: one event per cycle while the result side keeps out_tready high
// a two-entry path: a new beat is taken while a finished result waits
// reset: synchronous active-low rst_n clears flags, valids and configuration registers to defaults
// top level of the bus member transmit handshake; uses bmth_pkg
`default_nettype none
module bus_member_transmit_handshake (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // peer_field, source_address, fail_reason, class_match, device_ready, zero fill
  input  wire logic [23:0]                       in_tdata,
  // req_type
  input  wire logic [3:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // send_kind, event_address, fail_code, timer_arm, timer_stop, timeout_ms,
  // is_active, has_pending, zero fill
  output logic [39:0]                            out_tdata,
  // app_event
  output logic [3:0]                             out_tuser,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bmth_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [bmth_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bmth_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import bmth_pkg::*;

  logic [6:0]  own_address_r;
  logic [63:0] topic_low_r;
  logic [63:0] topic_high_r;
  logic [15:0] idle_tmo_r;
  logic [15:0] resp_tmo_r;

  logic active_r, pending_r, sent_wait_r;
  logic active_nxt, pending_nxt, sent_wait_nxt, clear_addr_nxt;

  logic       in_valid_r;
  in_beat_t   in_beat_r;
  logic [3:0] in_req_r;

  logic       out_valid_r;
  out_beat_t  out_beat_r;
  app_event_t out_ev_r;

  out_beat_t  res;
  app_event_t res_ev;

  logic advance, cfg_wr;
  logic [2:0] cfg_idx;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_beat_r <= in_beat_t'(in_tdata[19:0]);
      in_req_r  <= in_tuser;
    end
  end

  // event handling
  always_comb begin
    logic own_hit, rearm, topic_hit;
    own_hit   = (in_beat_r.peer_field == {1'b0, own_address_r});
    topic_hit = in_beat_r.peer_field[6] ? topic_high_r[in_beat_r.peer_field[5:0]]
                                        : topic_low_r[in_beat_r.peer_field[5:0]];
    rearm          = 1'b0;
    res            = '0;
    res_ev         = EV_NONE;
    active_nxt     = active_r;
    pending_nxt    = pending_r;
    sent_wait_nxt  = sent_wait_r;
    clear_addr_nxt = 1'b0;
    if (in_req_r == REQ_START) begin
      if (in_beat_r.device_ready) begin
        active_nxt        = 1'b1;
        res.timer_arm     = 1'b1;
        res.timeout_ms    = idle_tmo_r;
        res_ev            = EV_CONNECTED;
        res.event_address = {1'b0, own_address_r};
      end else begin
        res_ev = EV_REREGISTER;
      end
    end else if (active_r) begin
      case (in_req_r)
        REQ_TURN: begin
          rearm = 1'b1;
          if (own_hit) begin
            if (pending_r) begin
              res.send_kind = SEND_PACKET;
              sent_wait_nxt = 1'b1;
            end else begin
              res.send_kind = SEND_SUCCESS;
            end
          end
        end
        REQ_FAIL: begin
          rearm = 1'b1;
          if (sent_wait_r) begin
            sent_wait_nxt = 1'b0;
            if (in_beat_r.fail_reason > MAX_RETRY_REASON) begin
              res_ev        = EV_TX_FAILED;
              res.fail_code = in_beat_r.fail_reason;
              pending_nxt   = 1'b0;
            end
          end
        end
        REQ_SUCCESS: begin
          rearm = 1'b1;
          if (sent_wait_r) begin
            sent_wait_nxt = 1'b0;
            res_ev        = EV_TX_OK;
            pending_nxt   = 1'b0;
          end
        end
        REQ_XMIT: begin
          rearm = 1'b1;
          if (in_beat_r.peer_field[7]) begin
            if (topic_hit) begin
              res_ev            = EV_TOPIC_DATA;
              res.event_address = in_beat_r.peer_field;
            end
          end else if (own_hit) begin
            res_ev            = EV_PEER_DATA;
            res.event_address = {1'b0, in_beat_r.source_address};
            res.send_kind     = SEND_SUCCESS;
          end
        end
        REQ_JOIN, REQ_QUIT: begin
          if (own_hit && (in_req_r == REQ_QUIT || !in_beat_r.class_match)) begin
            active_nxt     = 1'b0;
            pending_nxt    = 1'b0;
            sent_wait_nxt  = 1'b0;
            res.timer_stop = 1'b1;
            res_ev         = EV_REREGISTER;
          end else begin
            rearm             = 1'b1;
            res_ev            = (in_req_r == REQ_JOIN) ? EV_JOINED : EV_QUIT;
            res.event_address = in_beat_r.peer_field;
          end
        end
        REQ_APP: begin
          pending_nxt = 1'b1;
        end
        REQ_TIMEOUT: begin
          active_nxt     = 1'b0;
          pending_nxt    = 1'b0;
          sent_wait_nxt  = 1'b0;
          clear_addr_nxt = 1'b1;
          res.timer_stop = 1'b1;
          res_ev         = EV_DISCONNECTED;
        end
        default: begin
        end
      endcase
    end
    if (rearm) begin
      res.timer_arm  = 1'b1;
      res.timeout_ms = sent_wait_nxt ? resp_tmo_r : idle_tmo_r;
    end
    res.is_active   = active_nxt;
    res.has_pending = pending_nxt;
  end

  // flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pending_r   <= 1'b0;
      sent_wait_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        active_r    <= active_nxt;
        pending_r   <= pending_nxt;
        sent_wait_r <= sent_wait_nxt;
      end
    end
    if (advance && in_valid_r) begin
      out_beat_r <= res;
      out_ev_r   <= res_ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_beat_r};
  assign out_tuser  = out_ev_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      topic_low_r   <= '0;
      topic_high_r  <= '0;
      idle_tmo_r    <= IDLE_TMO_RESET;
      resp_tmo_r    <= RESPONSE_TMO_RESET;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_OWN_ADDRESS:  own_address_r <= cfg_pwdata[6:0];
          REG_TOPIC_LOW:    topic_low_r   <= cfg_pwdata;
          REG_TOPIC_HIGH:   topic_high_r  <= cfg_pwdata;
          REG_IDLE_TMO:     idle_tmo_r    <= cfg_pwdata[15:0];
          REG_RESPONSE_TMO: resp_tmo_r    <= cfg_pwdata[15:0];
          default: begin
          end
        endcase
      end
      // timeout clears the address
      if (advance && in_valid_r && clear_addr_nxt) begin
        own_address_r <= '0;
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OWN_ADDRESS:  cfg_prdata = {57'd0, own_address_r};
      REG_TOPIC_LOW:    cfg_prdata = topic_low_r;
      REG_TOPIC_HIGH:   cfg_prdata = topic_high_r;
      REG_IDLE_TMO:     cfg_prdata = {48'd0, idle_tmo_r};
      REG_RESPONSE_TMO: cfg_prdata = {48'd0, resp_tmo_r};
      default:          cfg_prdata = '0;
    endcase
  end

  a_inactive_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> !pending_r && !sent_wait_r)
    else $error("flags set while inactive");

  a_wait_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sent_wait_r |-> pending_r)
    else $error("awaiting answer without pending packet");

  a_arm_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_beat_r.timer_arm && out_beat_r.timer_stop) &&
                    (out_beat_r.timer_arm || out_beat_r.timeout_ms == 16'd0))
    else $error("inconsistent timer fields");

  a_disconnect_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && res_ev == EV_DISCONNECTED
    |=> own_address_r == 7'd0 && !active_r)
    else $error("timeout did not clear member state");

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for bus_member_transmit_handshake: event beats in, one reply beat out
// a scoreboard class predicts each reply from its own copy of the member flags and registers
// depends on bmth_pkg and the block itself
`default_nettype none
module tb;
  import bmth_pkg::*;

  localparam logic [3:0] REQ_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] REQ_LAST_UNUSED  = 4'd15;
  localparam int         PHASES           = 7;
  localparam int         BEATS_PER_PHASE  = 100;

  typedef struct packed {
    app_event_t ev;
    out_beat_t  beat;
  } reply_t;

  class member_scoreboard;
    logic [6:0]  own_addr;
    logic [63:0] mask_lo;
    logic [63:0] mask_hi;
    logic [15:0] idle_tmo;
    logic [15:0] resp_tmo;
    logic        active;
    logic        pending;
    logic        sent_wait;
    reply_t      expected_replies[$];
    int          errors;

    function new();
      own_addr  = '0;
      mask_lo   = '0;
      mask_hi   = '0;
      idle_tmo  = IDLE_TMO_RESET;
      resp_tmo  = RESPONSE_TMO_RESET;
      active    = 1'b0;
      pending   = 1'b0;
      sent_wait = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] value);
      case (idx)
        REG_OWN_ADDRESS:  own_addr = value[6:0];
        REG_TOPIC_LOW:    mask_lo  = value;
        REG_TOPIC_HIGH:   mask_hi  = value;
        REG_IDLE_TMO:     idle_tmo = value[15:0];
        REG_RESPONSE_TMO: resp_tmo = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [3:0] req, in_beat_t b);
      reply_t     r;
      logic       rearm;
      logic [7:0] own;
      r     = '0;
      rearm = 1'b0;
      own   = {1'b0, own_addr};
      if (req == REQ_START) begin
        if (b.device_ready) begin
          active                = 1'b1;
          r.beat.timer_arm      = 1'b1;
          r.beat.timeout_ms     = idle_tmo;
          r.ev                  = EV_CONNECTED;
          r.beat.event_address  = own;
        end else begin
          r.ev = EV_REREGISTER;
        end
      end else if (active) begin
        case (req)
          REQ_TURN: begin
            rearm = 1'b1;
            if (b.peer_field == own) begin
              if (pending) begin
                r.beat.send_kind = SEND_PACKET;
                sent_wait        = 1'b1;
              end else begin
                r.beat.send_kind = SEND_SUCCESS;
              end
            end
          end
          REQ_FAIL: begin
            rearm = 1'b1;
            if (sent_wait) begin
              sent_wait = 1'b0;
              if (b.fail_reason > MAX_RETRY_REASON) begin
                r.ev             = EV_TX_FAILED;
                r.beat.fail_code = b.fail_reason;
                pending          = 1'b0;
              end
            end
          end
          REQ_SUCCESS: begin
            rearm = 1'b1;
            if (sent_wait) begin
              sent_wait = 1'b0;
              r.ev      = EV_TX_OK;
              pending   = 1'b0;
            end
          end
          REQ_XMIT: begin
            rearm = 1'b1;
            if (b.peer_field[7]) begin
              if (b.peer_field[6] ? mask_hi[b.peer_field[5:0]] : mask_lo[b.peer_field[5:0]]) begin
                r.ev                 = EV_TOPIC_DATA;
                r.beat.event_address = b.peer_field;
              end
            end else if (b.peer_field == own) begin
              r.ev                 = EV_PEER_DATA;
              r.beat.event_address = {1'b0, b.source_address};
              r.beat.send_kind     = SEND_SUCCESS;
            end
          end
          REQ_JOIN, REQ_QUIT: begin
            if (b.peer_field == own && (req == REQ_QUIT || !b.class_match)) begin
              active            = 1'b0;
              pending           = 1'b0;
              sent_wait         = 1'b0;
              r.beat.timer_stop = 1'b1;
              r.ev              = EV_REREGISTER;
            end else begin
              rearm                = 1'b1;
              r.ev                 = (req == REQ_JOIN) ? EV_JOINED : EV_QUIT;
              r.beat.event_address = b.peer_field;
            end
          end
          REQ_APP: pending = 1'b1;
          REQ_TIMEOUT: begin
            active            = 1'b0;
            pending           = 1'b0;
            sent_wait         = 1'b0;
            own_addr          = '0;
            r.beat.timer_stop = 1'b1;
            r.ev              = EV_DISCONNECTED;
          end
          default: ;
        endcase
      end
      if (rearm) begin
        r.beat.timer_arm  = 1'b1;
        r.beat.timeout_ms = sent_wait ? resp_tmo : idle_tmo;
      end
      r.beat.is_active   = active;
      r.beat.has_pending = pending;
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic [3:0] tuser);
      reply_t    want;
      out_beat_t got;
      got = out_beat_t'(tdata[32:0]);
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: result beat expected none actual %0h/%0h", $time, tuser, tdata);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("send_kind", want.beat.send_kind, got.send_kind);
      compare_field("app_event", want.ev, tuser);
      compare_field("event_address", want.beat.event_address, got.event_address);
      compare_field("fail_code", want.beat.fail_code, got.fail_code);
      compare_field("timer_arm", want.beat.timer_arm, got.timer_arm);
      compare_field("timer_stop", want.beat.timer_stop, got.timer_stop);
      compare_field("timeout_ms", want.beat.timeout_ms, got.timeout_ms);
      compare_field("is_active", want.beat.is_active, got.is_active);
      compare_field("has_pending", want.beat.has_pending, got.has_pending);
      compare_field("tdata fill", '0, tdata[39:33]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic [3:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [39:0]           out_tdata;
  logic [3:0]            out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  member_scoreboard sb = new();
  int beats_sent   = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int send_quiet   = 0;
  int recv_quiet   = 0;

  bus_member_transmit_handshake dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly a random wait before each beat, with occasional runs of back-to-back beats
  function automatic int draw_wait(inout int quiet_run);
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0)
      quiet_run = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic in_beat_t make_beat(logic [7:0] peer, logic [6:0] src, logic [2:0] reason,
                                         logic cls, logic rdy);
    in_beat_t b;
    b.peer_field     = peer;
    b.source_address = src;
    b.fail_reason    = reason;
    b.class_match    = cls;
    b.device_ready   = rdy;
    return b;
  endfunction

  task automatic send_beat(input logic [3:0] req, input in_beat_t b);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(req, b);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_replies.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, value);
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [6:0] addr, input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] idle, input logic [15:0] resp);
    write_reg(REG_OWN_ADDRESS, {57'b0, addr});
    write_reg(REG_TOPIC_LOW, lo);
    write_reg(REG_TOPIC_HIGH, hi);
    write_reg(REG_IDLE_TMO, {48'b0, idle});
    write_reg(REG_RESPONSE_TMO, {48'b0, resp});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // steer toward connected sessions that run the turn / answer handshake
  task automatic pick_event(output logic [3:0] req, output in_beat_t b);
    int         roll;
    logic [7:0] own;
    own = {1'b0, sb.own_addr};
    b   = make_beat(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    roll = $urandom_range(0, 99);
    if (!sb.active) begin
      if (roll < 70) begin
        req            = REQ_START;
        b.device_ready = 1'b1;
      end else if (roll < 80) begin
        req = REQ_START;
      end else begin
        req = 4'($urandom_range(0, 15));
      end
    end else if (roll < 15) begin
      req = REQ_APP;
    end else if (roll < 35) begin
      req          = REQ_TURN;
      b.peer_field = own;
    end else if (roll < 40) begin
      req = REQ_TURN;
    end else if (roll < 52) begin
      req = REQ_FAIL;
    end else if (roll < 62) begin
      req = REQ_SUCCESS;
    end else if (roll < 70) begin
      req          = REQ_XMIT;
      b.peer_field = own;
    end else if (roll < 78) begin
      req             = REQ_XMIT;
      b.peer_field[7] = 1'b1;
    end else if (roll < 82) begin
      req = REQ_XMIT;
    end else if (roll < 87) begin
      req = REQ_JOIN;
      if ($urandom_range(0, 3) == 0) b.peer_field = own;
    end else if (roll < 90) begin
      req = REQ_QUIT;
      if ($urandom_range(0, 4) == 0) b.peer_field = own;
    end else if (roll < 92) begin
      req = REQ_TIMEOUT;
    end else if (roll < 95) begin
      req = 4'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
    end else if (roll < 98) begin
      req = REQ_START;
    end else begin
      req = 4'($urandom_range(0, 15));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.expected_replies.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [3:0]  req;
    in_beat_t    b;
    logic [6:0]  addr;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] idle;
    logic [15:0] resp;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    program_regs(7'd127, 64'h1, 64'h8000_0000_0000_0000, IDLE_TMO_RESET, RESPONSE_TMO_RESET);
    send_beat(REQ_TURN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_START, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_START, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b1));
    send_beat(REQ_FAIL, make_beat(8'd0, 7'd0, 3'd7, 1'b0, 1'b0));
    send_beat(REQ_TURN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_APP, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_APP, make_beat(8'd255, 7'd127, 3'd7, 1'b1, 1'b1));
    send_beat(REQ_TURN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_SUCCESS, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_APP, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_TURN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_FAIL, make_beat(8'd0, 7'd0, 3'd3, 1'b0, 1'b0));
    send_beat(REQ_TURN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_FAIL, make_beat(8'd0, 7'd0, 3'd4, 1'b0, 1'b0));
    send_beat(REQ_TURN, make_beat(8'd255, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_XMIT, make_beat(8'd127, 7'd127, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_XMIT, make_beat(8'd128, 7'd5, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_XMIT, make_beat(8'd255, 7'd5, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_XMIT, make_beat(8'd200, 7'd5, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_JOIN, make_beat(8'd127, 7'd0, 3'd0, 1'b1, 1'b0));
    send_beat(REQ_QUIT, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_LAST_UNUSED, make_beat(8'd127, 7'd127, 3'd7, 1'b1, 1'b1));
    send_beat(REQ_JOIN, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_START, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b1));
    send_beat(REQ_QUIT, make_beat(8'd127, 7'd0, 3'd0, 1'b0, 1'b0));
    send_beat(REQ_START, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b1));
    send_beat(REQ_TIMEOUT, make_beat(8'd0, 7'd0, 3'd0, 1'b0, 1'b0));
    drain_replies();

    for (int phase = 0; phase < PHASES; phase++) begin
      addr = 7'($urandom_range(0, 127));
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      idle = 16'($urandom_range(1, 65535));
      resp = 16'($urandom_range(1, 65535));
      case (phase)
        0: begin
          addr = '0;
          lo   = '0;
          hi   = '0;
          idle = 16'd1;
          resp = 16'd1;
        end
        1: begin
          addr = '1;
          lo   = '1;
          hi   = '1;
          idle = '1;
          resp = '1;
        end
        3: begin
          addr = 7'd1;
          hi   = '0;
          idle = IDLE_TMO_RESET;
          resp = RESPONSE_TMO_RESET;
        end
        default: ;
      endcase
      program_regs(addr, lo, hi, idle, resp);
      repeat (BEATS_PER_PHASE) begin
        pick_event(req, b);
        send_beat(req, b);
      end
      drain_replies();
    end

    repeat (10) @(negedge clk);
    $display("covered %0d event beats and %0d reply beats over %0d register settings",
             beats_sent, results_seen, PHASES + 1);
    $display("%0d register writes, %0d field mismatches", reg_writes, sb.errors);
    if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
